/* hdl/tun_pkg.sv */
// ----------------------------------------------------------------------------
// tun_pkg
// Widths, constants and shared types of the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

    localparam int EDGE_MAG_W = 16;               // edge magnitude after scaling
    localparam int EDGE_W     = EDGE_MAG_W + 1;   // signed scaled edge
    localparam int PROD_W     = 2 * EDGE_W;       // signed edge product / cross
    localparam int MAG_W      = PROD_W - 1;       // cross component magnitude
    localparam int SQ_W       = 2 * MAG_W;        // squared magnitude
    localparam int SUM_W      = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W     = 36;               // square root result bits
    localparam int TST_W      = 2 * ROOT_W;       // root trial compare width
    localparam int FRAC_SH    = 16;               // numerator scale 2^16; normal is Q1.15
    localparam int NUM_W      = MAG_W + FRAC_SH + 1;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int Q_W        = 16;               // quotient bits
    localparam int DCMP_W     = DEN_W + Q_W;      // divider compare width
    localparam int OUT_W      = 16;

    localparam logic [OUT_W-1:0] Q15_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] Q15_MIN = 16'h8000;
    localparam logic [Q_W:0]     Q15_ONE = 17'd32768;

    typedef struct packed {
        logic                        deg;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
    } side_t;

    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } dside_t;

endpackage

`default_nettype wire

/* hdl/triangle_unit_normal.sv */
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: cross product (b-a) x (c-a) divided by its
// length, signed Q1.15 out, with a flag for a zero cross product.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: three vertices a, b, c, signed Q8.8 in COORD_BITS bits.
//   Output channel m_*: n_x, n_y, n_z in signed Q1.15 and the degenerate flag.
//   Both channels use valid/ready; an item moves when both are high.
// Stages: edges, magnitudes and scaling shift, scaled edges, products,
//   cross, squares, sum, 36 square root stages, divider setup,
//   16 divider stages, saturation/output.
// Throughput: one item per cycle when not stalled; every stage is a register
//   stage and the whole pipeline advances together.
// Stall: while an output item waits with m_ready low, the pipeline holds and
//   s_ready drops; nothing in flight is lost or repeated.
// Reset: aresetn low clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_a_x,
    input  wire logic signed [COORD_BITS-1:0] s_a_y,
    input  wire logic signed [COORD_BITS-1:0] s_a_z,
    input  wire logic signed [COORD_BITS-1:0] s_b_x,
    input  wire logic signed [COORD_BITS-1:0] s_b_y,
    input  wire logic signed [COORD_BITS-1:0] s_b_z,
    input  wire logic signed [COORD_BITS-1:0] s_c_x,
    input  wire logic signed [COORD_BITS-1:0] s_c_y,
    input  wire logic signed [COORD_BITS-1:0] s_c_z,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [OUT_W-1:0]           m_n_x,
    output logic signed [OUT_W-1:0]           m_n_y,
    output logic signed [OUT_W-1:0]           m_n_z,
    output logic                              m_degenerate
);

    localparam int EW   = COORD_BITS + 1;
    localparam int SH_W = $clog2(EW + 1);

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // edges
    logic                 e_vld_reg;
    logic signed [EW-1:0] e_reg [0:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (adv) begin
            e_vld_reg <= s_valid;
        end
        if (adv) begin
            e_reg[0] <= EW'(s_b_x) - EW'(s_a_x);
            e_reg[1] <= EW'(s_b_y) - EW'(s_a_y);
            e_reg[2] <= EW'(s_b_z) - EW'(s_a_z);
            e_reg[3] <= EW'(s_c_x) - EW'(s_a_x);
            e_reg[4] <= EW'(s_c_y) - EW'(s_a_y);
            e_reg[5] <= EW'(s_c_z) - EW'(s_a_z);
        end
    end

    // magnitudes and common scaling shift
    logic            m_vld_reg;
    logic [EW-1:0]   mg_reg [0:5];
    logic [5:0]      mn_reg;
    logic [SH_W-1:0] sh_reg;
    logic [EW-1:0]   mg_next [0:5];
    logic [EW-1:0]   or_mag;
    logic [SH_W-1:0] sh_next;

    always_comb begin
        or_mag = '0;
        for (int i = 0; i < 6; i++) begin
            mg_next[i] = e_reg[i][EW-1] ? EW'(-e_reg[i]) : EW'(e_reg[i]);
            or_mag     = or_mag | mg_next[i];
        end
        sh_next = '0;
        for (int i = EDGE_MAG_W; i < EW; i++) begin
            if (or_mag[i]) begin
                sh_next = SH_W'(i - EDGE_MAG_W + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= e_vld_reg;
        end
        if (adv) begin
            for (int i = 0; i < 6; i++) begin
                mg_reg[i] <= mg_next[i];
                mn_reg[i] <= e_reg[i][EW-1];
            end
            sh_reg <= sh_next;
        end
    end

    // scaled signed edges
    logic                     d_vld_reg;
    logic signed [EDGE_W-1:0] ed_reg [0:5];
    logic [EDGE_MAG_W-1:0]    sm [0:5];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            sm[i] = EDGE_MAG_W'(mg_reg[i] >> sh_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (adv) begin
            d_vld_reg <= m_vld_reg;
        end
        if (adv) begin
            for (int i = 0; i < 6; i++) begin
                ed_reg[i] <= mn_reg[i] ? -$signed({1'b0, sm[i]}) : $signed({1'b0, sm[i]});
            end
        end
    end

    // products
    logic                     p_vld_reg;
    logic signed [PROD_W-1:0] p_reg [0:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (adv) begin
            p_vld_reg <= d_vld_reg;
        end
        if (adv) begin
            p_reg[0] <= PROD_W'(ed_reg[1]) * PROD_W'(ed_reg[5]);
            p_reg[1] <= PROD_W'(ed_reg[2]) * PROD_W'(ed_reg[4]);
            p_reg[2] <= PROD_W'(ed_reg[2]) * PROD_W'(ed_reg[3]);
            p_reg[3] <= PROD_W'(ed_reg[0]) * PROD_W'(ed_reg[5]);
            p_reg[4] <= PROD_W'(ed_reg[0]) * PROD_W'(ed_reg[4]);
            p_reg[5] <= PROD_W'(ed_reg[1]) * PROD_W'(ed_reg[3]);
        end
    end

    // cross product as sign and magnitude
    logic                     x_vld_reg;
    logic [2:0]               xn_reg;
    logic [MAG_W-1:0]         xm_reg [0:2];
    logic signed [PROD_W-1:0] x_next [0:2];

    assign x_next[0] = p_reg[0] - p_reg[1];
    assign x_next[1] = p_reg[2] - p_reg[3];
    assign x_next[2] = p_reg[4] - p_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_vld_reg <= 1'b0;
        end else if (adv) begin
            x_vld_reg <= p_vld_reg;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                xn_reg[i] <= x_next[i][PROD_W-1];
                xm_reg[i] <= x_next[i][PROD_W-1] ? MAG_W'(-x_next[i]) : MAG_W'(x_next[i]);
            end
        end
    end

    // squares
    logic             q_vld_reg;
    logic [2:0]       qn_reg;
    logic [MAG_W-1:0] qm_reg [0:2];
    logic [SQ_W-1:0]  qs_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else if (adv) begin
            q_vld_reg <= x_vld_reg;
        end
        if (adv) begin
            qn_reg <= xn_reg;
            for (int i = 0; i < 3; i++) begin
                qm_reg[i] <= xm_reg[i];
                qs_reg[i] <= SQ_W'(xm_reg[i]) * SQ_W'(xm_reg[i]);
            end
        end
    end

    // sum of squares, then one root bit per stage
    logic              sq_vld_reg  [0:ROOT_W];
    side_t             sq_side_reg [0:ROOT_W];
    logic [SUM_W-1:0]  sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    logic [SUM_W-1:0]  sum_next;

    assign sum_next = SUM_W'(qs_reg[0]) + SUM_W'(qs_reg[1]) + SUM_W'(qs_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= q_vld_reg;
        end
        if (adv) begin
            sq_side_reg[0].deg <= (sum_next == '0);
            sq_side_reg[0].neg <= qn_reg;
            for (int i = 0; i < 3; i++) begin
                sq_side_reg[0].mag[i] <= qm_reg[i];
            end
            sq_rem_reg[0]  <= sum_next;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - j;
        logic [TST_W-1:0] trial;
        logic [TST_W-1:0] rext;
        logic             ge;

        assign trial = (TST_W'(sq_root_reg[j]) << (B + 1)) | (TST_W'(1) << (2 * B));
        assign rext  = TST_W'(sq_rem_reg[j]);
        assign ge    = rext >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
            if (adv) begin
                sq_side_reg[j+1] <= sq_side_reg[j];
                sq_rem_reg[j+1]  <= ge ? SUM_W'(rext - trial) : sq_rem_reg[j];
                sq_root_reg[j+1] <= sq_root_reg[j] | (ROOT_W'(ge) << B);
            end
        end
    end

    // divider setup: num = |x| * 2^16 + len, den = 2 * len
    logic              pp_vld_reg;
    dside_t            pp_side_reg;
    logic [NUM_W-1:0]  pp_num_reg [0:2];
    logic [DEN_W-1:0]  pp_den_reg;
    logic [ROOT_W-1:0] len;

    assign len = sq_root_reg[ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_vld_reg <= 1'b0;
        end else if (adv) begin
            pp_vld_reg <= sq_vld_reg[ROOT_W];
        end
        if (adv) begin
            pp_side_reg.deg <= sq_side_reg[ROOT_W].deg;
            pp_side_reg.neg <= sq_side_reg[ROOT_W].neg;
            for (int i = 0; i < 3; i++) begin
                pp_num_reg[i] <= (NUM_W'(sq_side_reg[ROOT_W].mag[i]) << FRAC_SH)
                                 + NUM_W'(len);
            end
            pp_den_reg <= {len, 1'b0};
        end
    end

    logic   dv_vld_reg  [0:Q_W-1];
    dside_t dv_side_reg [0:Q_W-1];
    logic [Q_W-1:0] dq [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_div
        tun_div u_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (pp_num_reg[i]),
            .den_i (pp_den_reg),
            .q_o   (dq[i])
        );
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_dside
        logic   vin;
        dside_t sin;
        if (k == 0) begin : g_first
            assign vin = pp_vld_reg;
            assign sin = pp_side_reg;
        end else begin : g_next
            assign vin = dv_vld_reg[k-1];
            assign sin = dv_side_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[k] <= vin;
            end
            if (adv) begin
                dv_side_reg[k] <= sin;
            end
        end
    end

    // saturate and output
    logic                    o_vld_reg;
    logic [OUT_W-1:0]        on_reg [0:2];
    logic                    odeg_reg;
    logic [OUT_W-1:0]        on_next [0:2];
    dside_t                  dlast;

    assign dlast = dv_side_reg[Q_W-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dlast.deg) begin
                on_next[i] = '0;
            end else if (dlast.neg[i]) begin
                on_next[i] = ({1'b0, dq[i]} > Q15_ONE) ? Q15_MIN : OUT_W'(-dq[i]);
            end else begin
                on_next[i] = dq[i][Q_W-1] ? Q15_MAX : OUT_W'(dq[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (adv) begin
            o_vld_reg <= dv_vld_reg[Q_W-1];
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                on_reg[i] <= on_next[i];
            end
            odeg_reg <= dlast.deg;
        end
    end

    assign m_valid      = o_vld_reg;
    assign m_n_x        = on_reg[0];
    assign m_n_y        = on_reg[1];
    assign m_n_z        = on_reg[2];
    assign m_degenerate = odeg_reg;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_n_x == 0 && m_n_y == 0 && m_n_z == 0)
        else $error("degenerate item with nonzero normal");

    a_nondeg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_n_x != 0 || m_n_y != 0 || m_n_z != 0)
        else $error("normal of a proper triangle is zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

`default_nettype wire

/* hdl/tun_div.sv */
// ----------------------------------------------------------------------------
// tun_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div
    import tun_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num_i,
    input  wire logic [DEN_W-1:0] den_i,
    output logic      [Q_W-1:0]   q_o
);

    logic [NUM_W-1:0] rem_reg [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [0:Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [DCMP_W-1:0] dsh;
        logic [DCMP_W-1:0] rext;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = num_i;
            assign den_in = den_i;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign dsh  = DCMP_W'(den_in) << B;
        assign rext = DCMP_W'(rem_in);
        assign ge   = rext >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? NUM_W'(rext - dsh) : rem_in;
                den_reg[k] <= den_in;
                q_reg[k]   <= q_in | (Q_W'(ge) << B);
            end
        end
    end

    assign q_o = q_reg[Q_W-1];

endmodule

`default_nettype wire
